### design/lcs_pkg.sv
// shared types and constants for the linear contrast stretch block
package lcs_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned RemW   = 2 * PixW;
  localparam int unsigned NCells = PixW;

  localparam logic [PixW-1:0] PixMax    = 8'd255;
  localparam logic [PixW-1:0] PixZero   = 8'd0;
  localparam logic            ReqScan   = 1'b0;
  localparam logic            ReqMap    = 1'b1;

  // word carried from cell to cell along the divider chain
  typedef struct packed {
    logic            valid;
    logic            divide;
    logic [RemW-1:0] rem;
    logic [PixW-1:0] dvs;
    logic [PixW-1:0] quo;
  } lcs_word_t;

endpackage

### design/lcs_entry.sv
// min/max tracking and set-up of one map word for the divider chain
module lcs_entry
  import lcs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic            accept_i,
  input  logic            req_type_i,
  input  logic [PixW-1:0] pixel_in_i,
  input  logic            first_of_image_i,
  output lcs_word_t       word_o
);

  logic [PixW-1:0] min_q, min_d;
  logic [PixW-1:0] max_q, max_d;
  lcs_word_t       word_q, word_d;
  logic [PixW-1:0] diff;

  // running minimum and maximum over scan words
  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (accept_i && (req_type_i == ReqScan)) begin
      if (first_of_image_i) begin
        min_d = pixel_in_i;
        max_d = pixel_in_i;
      end else begin
        if (pixel_in_i < min_q) min_d = pixel_in_i;
        if (pixel_in_i > max_q) max_d = pixel_in_i;
      end
    end
  end

  // special cases resolve here, the general case gets 255*(p-min) as dividend
  always_comb begin
    diff          = pixel_in_i - min_q;
    word_d        = '0;
    word_d.valid  = accept_i && (req_type_i == ReqMap);
    if (min_q >= max_q) begin
      word_d.quo = pixel_in_i;
    end else if (pixel_in_i <= min_q) begin
      word_d.quo = PixZero;
    end else if (pixel_in_i >= max_q) begin
      word_d.quo = PixMax;
    end else begin
      word_d.divide = 1'b1;
      word_d.rem    = {diff, {PixW{1'b0}}} - {{PixW{1'b0}}, diff};
      word_d.dvs    = max_q - min_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= PixMax;
      max_q <= PixZero;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // entry stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (advance_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

### design/lcs_cell.sv
// one restoring-division cell: settles a single quotient bit
module lcs_cell
  import lcs_pkg::*;
#(
  parameter int unsigned Bit = 7
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  lcs_word_t word_i,
  output lcs_word_t word_o
);

  lcs_word_t       word_q, word_d;
  logic [RemW-1:0] shifted;

  // trial subtract of the divisor aligned to this bit
  always_comb begin
    shifted = {{PixW{1'b0}}, word_i.dvs} << Bit;
    word_d  = word_i;
    if (word_i.divide && (word_i.rem >= shifted)) begin
      word_d.rem      = word_i.rem - shifted;
      word_d.quo[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (advance_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

### design/linear_contrast_stretch.sv
// top level of the 8-bit linear contrast stretch
//
// Use: feed the image twice on the input channel. Scan words (req_type 0)
// update the running min and max; first_of_image on a scan word restarts
// them at that pixel. Map words (req_type 1) each return one stretched
// pixel floor(255*(p-min)/(max-min)) on the output channel; scan words
// return nothing. Flat or unscanned images pass pixels unchanged.
// A map word sees the min/max left by all scan words accepted before it.
// A map word passes one entry register and then a chain of 8 division
// cells, one quotient bit per cell, on its way to out_valid_o.
// Throughput: one word per cycle while no output word is held; the chain shifts whenever it is not held.
// Stall: when the output word waits under out_stall_i the whole chain
// holds and in_stall_o is raised; as soon as it is taken the chain moves.
// Reset: min returns to 255, max to 0, and all words in flight are dropped.
module linear_contrast_stretch
  import lcs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            req_type_i,
  input  logic [PixW-1:0] pixel_in_i,
  input  logic            first_of_image_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [PixW-1:0] pixel_out_o
);

  lcs_word_t chain [NCells+1];
  logic      advance;
  logic      accept;

  // the chain moves unless the finished word is held by the receiver
  assign advance    = !(chain[NCells].valid && out_stall_i);
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  lcs_entry u_entry (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .accept_i         (accept),
    .req_type_i       (req_type_i),
    .pixel_in_i       (pixel_in_i),
    .first_of_image_i (first_of_image_i),
    .word_o           (chain[0])
  );

  // division cells, most significant quotient bit first
  for (genvar g = 0; g < NCells; g++) begin : g_cell
    lcs_cell #(
      .Bit (NCells - 1 - g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .word_i    (chain[g]),
      .word_o    (chain[g+1])
    );
  end

  assign out_valid_o = chain[NCells].valid;
  assign pixel_out_o = chain[NCells].quo;

endmodule

### design/lcs_checker.sv
// port-level checks for the linear contrast stretch, bound to the top level
module lcs_checker
  import lcs_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            req_type_i,
  input logic [PixW-1:0] pixel_in_i,
  input logic            first_of_image_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [PixW-1:0] pixel_out_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_out_o))
    else $error("stalled output word changed");

  // input is only held back by a waiting output word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held output word");

  // a held output word freezes the whole chain
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output word held");

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(req_type_i)
    && $stable(pixel_in_i) && $stable(first_of_image_i))
    else $error("stalled input word changed");

endmodule

bind linear_contrast_stretch lcs_checker u_lcs_checker (.*);

### tb/linear_contrast_stretch_tb.sv
// self-checking testbench for the linear contrast stretch block
`timescale 1ns / 1ps

module linear_contrast_stretch_tb
  import lcs_pkg::*;
;

  // tracks the running min/max and queues the stretched pixels the block owes
  class stretch_scoreboard;
    logic [PixW-1:0] min_pix;
    logic [PixW-1:0] max_pix;
    logic [PixW-1:0] owed_pixels[$];
    int unsigned     mismatches;
    int unsigned     checked;

    function new();
      min_pix    = PixMax;
      max_pix    = PixZero;
      mismatches = 0;
      checked    = 0;
    endfunction

    // exact integer stretch of one pixel against the current min/max
    function logic [PixW-1:0] stretch(input logic [PixW-1:0] pix);
      int unsigned q;
      int unsigned pv;
      int unsigned lv;
      int unsigned hv;
      pv = pix;
      lv = min_pix;
      hv = max_pix;
      if (lv >= hv) return pix;
      if (pv <= lv) return PixZero;
      if (pv >= hv) return PixMax;
      q = (255 * (pv - lv)) / (hv - lv);
      if (q > 255) q = 255;
      return q[PixW-1:0];
    endfunction

    // an accepted input word: scans move min/max, maps owe one pixel
    function void note_word(input logic req, input logic [PixW-1:0] pix,
                            input logic first);
      if (req == ReqScan) begin
        if (first) begin
          min_pix = pix;
          max_pix = pix;
        end else begin
          if (pix < min_pix) min_pix = pix;
          if (pix > max_pix) max_pix = pix;
        end
      end else begin
        owed_pixels.push_back(stretch(pix));
      end
    endfunction

    // an accepted output word against the oldest owed pixel
    function void check_pixel(input logic [PixW-1:0] got);
      logic [PixW-1:0] want;
      checked++;
      if (owed_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: output word %0d with none owed, got %0d", $time, checked, got);
      end else begin
        want = owed_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: output word %0d pixel_out expected %0d, got %0d",
                     $time, checked, want, got);
        end
      end
    endfunction

    function int unsigned pending();
      return owed_pixels.size();
    endfunction
  endclass

  logic            clk_i            = 1'b0;
  logic            rst_ni           = 1'b0;
  logic            in_valid_i       = 1'b0;
  logic            in_stall_o;
  logic            req_type_i       = ReqScan;
  logic [PixW-1:0] pixel_in_i       = PixZero;
  logic            first_of_image_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i      = 1'b0;
  logic [PixW-1:0] pixel_out_o;

  logic            in_idle_en  = 1'b0;
  logic            out_idle_en = 1'b0;
  int unsigned     stall_left  = 0;
  int unsigned     words_sent  = 0;

  stretch_scoreboard sb;

  linear_contrast_stretch u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .pixel_in_i      (pixel_in_i),
    .first_of_image_i(first_of_image_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_out_o     (pixel_out_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // output stall in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watch both channels for accepted words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_word(req_type_i, pixel_in_i, first_of_image_i);
      if (out_valid_o && !out_stall_i)
        sb.check_pixel(pixel_out_o);
    end
  end

  // present one input word, with an optional idle burst before it
  task automatic send_word(input logic req, input logic [PixW-1:0] pix,
                           input logic first);
    int unsigned gap;
    gap = 0;
    if (in_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= req;
    pixel_in_i       <= pix;
    first_of_image_i <= first;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  // one image: a scan pass over a pixel band, then a map pass
  task automatic run_image();
    int unsigned lo;
    int unsigned hi;
    int unsigned npix;
    int unsigned nmap;
    int unsigned k;
    logic [PixW-1:0] pix;
    lo = $urandom_range(0, 255);
    hi = $urandom_range(lo, 255);
    case ($urandom_range(0, 7))
      0: hi = lo;
      1: begin
        lo = 0;
        hi = 255;
      end
      default: ;
    endcase
    npix = $urandom_range(1, 10);
    nmap = $urandom_range(1, 12);
    // stray word ahead of the image
    if ($urandom_range(0, 5) == 0)
      send_word(1'($urandom_range(0, 1)), PixW'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    for (k = 0; k < npix; k++) begin
      pix = PixW'($urandom_range(lo, hi));
      send_word(ReqScan, pix, k == 0);
    end
    for (k = 0; k < nmap; k++) begin
      if ($urandom_range(0, 7) == 0)
        pix = PixW'($urandom_range(0, 255));
      else
        pix = PixW'($urandom_range(lo, hi));
      send_word(ReqMap, pix, 1'($urandom_range(0, 1)));
      // occasional scan word breaking into the map pass
      if ($urandom_range(0, 15) == 0)
        send_word(ReqScan, PixW'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni      <= 1'b1;
    in_idle_en  <= 1'b1;
    out_idle_en <= 1'b1;
    @(posedge clk_i);

    // nothing scanned yet: pixels pass unchanged
    send_word(ReqMap,  8'd0,   1'b0);
    send_word(ReqMap,  8'd255, 1'b1);
    // flat image
    send_word(ReqScan, 8'd100, 1'b1);
    send_word(ReqMap,  8'd100, 1'b0);
    send_word(ReqMap,  8'd37,  1'b0);
    // band 40..200: below, at min, inside, at max, above
    send_word(ReqScan, 8'd40,  1'b0);
    send_word(ReqScan, 8'd200, 1'b0);
    send_word(ReqMap,  8'd0,   1'b0);
    send_word(ReqMap,  8'd40,  1'b0);
    send_word(ReqMap,  8'd41,  1'b0);
    send_word(ReqMap,  8'd199, 1'b0);
    send_word(ReqMap,  8'd200, 1'b0);
    send_word(ReqMap,  8'd255, 1'b0);
    // full range
    send_word(ReqScan, 8'd0,   1'b1);
    send_word(ReqScan, 8'd255, 1'b0);
    send_word(ReqMap,  8'd127, 1'b0);
    send_word(ReqMap,  8'd128, 1'b1);
    // narrowest band at the top
    send_word(ReqScan, 8'd255, 1'b1);
    send_word(ReqScan, 8'd254, 1'b0);
    send_word(ReqMap,  8'd254, 1'b0);
    send_word(ReqMap,  8'd255, 1'b0);
    send_word(ReqMap,  8'd100, 1'b0);

    // random images, no idling in the last stretch
    while (words_sent < 550) begin
      if (words_sent >= 460) begin
        in_idle_en  <= 1'b0;
        out_idle_en <= 1'b0;
      end else begin
        in_idle_en  <= ($urandom_range(0, 3) != 0);
        out_idle_en <= ($urandom_range(0, 3) != 0);
      end
      run_image();
    end
    in_valid_i <= 1'b0;

    // drain
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(1_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
